// ----- rtl/core/tmhq_pkg.sv -----
// ----------------------------------------------------------------------------
// tmhq_pkg: shared types and codes of the timer min-heap queue
// Command, heap entry and result formats, operation and result codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tmhq_pkg;

	// func code that carries no operation
	localparam logic [1:0] FUNC_UNDEF = 2'd3;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// longest answer of a query
	localparam logic [30:0] MAX_TIMEOUT = 31'h7FFF_FFFF;

	// answer of a query on an empty heap
	localparam logic signed [31:0] TIMEOUT_EMPTY = -32'sd1;

	typedef enum logic [1:0] {
		OP_REGISTER = 2'd0,
		OP_DISPATCH = 2'd1,
		OP_QUERY    = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		KIND_EXPIRED    = 3'd0,
		KIND_TIMEOUT    = 3'd1,
		KIND_REGISTERED = 3'd2,
		KIND_FULL       = 3'd3,
		KIND_NONE_DUE   = 3'd4
	} kind_t;

	typedef struct packed {
		logic [47:0] expire;
		logic [15:0] handle;
		logic [31:0] session;
	} entry_t;

	typedef struct packed {
		op_t                op;
		logic [47:0]        now_ms;
		logic [15:0]        handle;
		logic signed [31:0] session;
		logic [30:0]        interval;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_req_t;

	typedef struct packed {
		kind_t              kind;
		logic [15:0]        timer_handle;
		logic signed [31:0] timer_session;
		logic signed [31:0] timeout_ms;
		logic               last;
	} res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PUSH_RD,
		S_PUSH_CMP,
		S_DSP_RD,
		S_DSP_CHK,
		S_POP_LD,
		S_SIFT_RD,
		S_SIFT_CMP,
		S_DSP_END,
		S_QRY_RD,
		S_QRY_RES,
		S_EMIT
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/core/tmhq_chan_if.sv -----
// ----------------------------------------------------------------------------
// tmhq_chan_if: item channels of the timer min-heap queue
// Command channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface tmhq_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic [47:0]        now_ms;
	logic [15:0]        handle;
	logic signed [31:0] session;
	logic [30:0]        interval;

	modport source (output valid, func, now_ms, handle, session, interval, input ready);
	modport sink (input valid, func, now_ms, handle, session, interval, output ready);
endinterface

interface tmhq_evt_if;
	logic               valid;
	logic               ready;
	logic [2:0]         kind;
	logic [15:0]        timer_handle;
	logic signed [31:0] timer_session;
	logic signed [31:0] timeout_ms;
	logic               last;

	modport source (output valid, kind, timer_handle, timer_session, timeout_ms, last,
		input ready);
	modport sink (input valid, kind, timer_handle, timer_session, timeout_ms, last,
		output ready);
endinterface

`default_nettype wire

// ----- rtl/core/tmhq_front.sv -----
// ----------------------------------------------------------------------------
// tmhq_front: command intake of the timer min-heap queue
// Accepts items, decodes the operation, drops undefined codes and holds
// commands in a short queue for the heap engine.
// ----------------------------------------------------------------------------
`default_nettype none

module tmhq_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	tmhq_cmd_if.sink               cmd,
	output tmhq_pkg::cmd_req_t     req,
	input  wire logic              req_ready
);
	import tmhq_pkg::*;

	localparam int QAW = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	cmd_t             slot_q [QUEUE_DEPTH];
	logic [QAW-1:0]   wp_q;
	logic [QAW-1:0]   rp_q;
	logic [QCW-1:0]   fill_q;
	logic             take;
	logic             push;
	logic             pop;
	cmd_t             decoded;

	// decode the item into a command
	always_comb begin
		decoded.op       = op_t'(cmd.func);
		decoded.now_ms   = cmd.now_ms;
		decoded.handle   = cmd.handle;
		decoded.session  = cmd.session;
		decoded.interval = cmd.interval;
	end

	assign cmd.ready = (fill_q != QCW'(QUEUE_DEPTH));
	assign take      = cmd.valid && cmd.ready;
	assign push      = take && (cmd.func != FUNC_UNDEF);
	assign req.valid = (fill_q != '0);
	assign req.cmd   = slot_q[rp_q];
	assign pop       = req.valid && req_ready;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= decoded;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/tmhq_engine.sv -----
// ----------------------------------------------------------------------------
// tmhq_engine: heap engine of the timer min-heap queue
// Runs one command at a time over the heap memory: push with sift-up,
// dispatch with repeated root pop and sift-down, query of the root.
// ----------------------------------------------------------------------------
`default_nettype none

module tmhq_engine #(
	parameter int HEAP_DEPTH = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tmhq_pkg::cmd_req_t req,
	output tmhq_pkg::res_t         evt_data,
	output logic                   req_ready,
	output logic                   evt_valid,
	input  wire logic              evt_ready
);
	import tmhq_pkg::*;

	localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
	localparam int CW = $clog2(HEAP_DEPTH + 1);
	localparam int XW = AW + 1;

	entry_t          mem [HEAP_DEPTH];
	state_t          state_q, state_d;
	logic [CW-1:0]   cnt_q;
	logic [47:0]     lat_q;
	logic            stale_q;
	logic [AW-1:0]   pos_q;
	logic [XW-1:0]   child_q;
	entry_t          new_q, down_q, pend_q, rd0_q, rd1_q;
	logic            pend_v_q;
	res_t            res_q;
	logic            ov_q;
	res_t            od_q;

	logic            we;
	logic [AW-1:0]   wa, ra0, ra1;
	entry_t          wd;
	logic            emit;
	res_t            emit_res;
	logic            emit_ok;
	logic [AW-1:0]   up_idx;
	logic [CW-1:0]   cnt_m1;
	logic            child_in, right_ok, sel_r, sink, due, chk_go;
	logic [XW-1:0]   child_p1, c_idx;
	entry_t          ce;
	logic [48:0]     exp_sum;
	logic [47:0]     exp_sat, diff;
	logic [30:0]     tmo;

	// shared compare and index logic
	assign emit_ok  = !ov_q || evt_ready;
	assign up_idx   = (pos_q - 1'b1) >> 1;
	assign cnt_m1   = cnt_q - 1'b1;
	assign child_p1 = child_q + 1'b1;
	assign child_in = child_q < XW'(cnt_q);
	assign right_ok = child_p1 < XW'(cnt_q);
	assign sel_r    = right_ok && (rd0_q.expire > rd1_q.expire);
	assign c_idx    = sel_r ? child_p1 : child_q;
	assign ce       = sel_r ? rd1_q : rd0_q;
	assign sink     = down_q.expire >= ce.expire;
	assign due      = rd0_q.expire <= lat_q;
	assign chk_go   = !pend_v_q || emit_ok;
	assign exp_sum  = {1'b0, lat_q} + 49'(req.cmd.interval);
	assign exp_sat  = exp_sum[48] ? '1 : exp_sum[47:0];
	assign diff     = rd0_q.expire - lat_q;

	// query answer from the root
	always_comb begin
		if (rd0_q.expire <= lat_q) begin
			tmo = '0;
		end else if (diff > 48'(MAX_TIMEOUT)) begin
			tmo = MAX_TIMEOUT;
		end else begin
			tmo = diff[30:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					unique case (req.cmd.op)
						OP_REGISTER: state_d = (cnt_q == CW'(HEAP_DEPTH)) ? S_EMIT : S_PUSH_RD;
						OP_DISPATCH: state_d = S_DSP_RD;
						OP_QUERY:    state_d = S_QRY_RD;
						default:     state_d = S_IDLE;
					endcase
				end
			end
			S_PUSH_RD:  state_d = (pos_q == '0) ? S_EMIT : S_PUSH_CMP;
			S_PUSH_CMP: state_d = (new_q.expire < rd0_q.expire) ? S_PUSH_RD : S_EMIT;
			S_DSP_RD:   state_d = (cnt_q == '0) ? S_DSP_END : S_DSP_CHK;
			S_DSP_CHK: begin
				if (!due) begin
					state_d = S_DSP_END;
				end else if (chk_go) begin
					state_d = (cnt_m1 == '0) ? S_DSP_RD : S_POP_LD;
				end
			end
			S_POP_LD:   state_d = S_SIFT_RD;
			S_SIFT_RD:  state_d = child_in ? S_SIFT_CMP : S_DSP_RD;
			S_SIFT_CMP: state_d = sink ? S_SIFT_RD : S_DSP_RD;
			S_DSP_END:  state_d = emit_ok ? S_IDLE : S_DSP_END;
			S_QRY_RD:   state_d = (cnt_q == '0) ? S_EMIT : S_QRY_RES;
			S_QRY_RES:  state_d = S_EMIT;
			S_EMIT:     state_d = emit_ok ? S_IDLE : S_EMIT;
			default:    state_d = S_IDLE;
		endcase
	end

	// memory control, handshake and result outputs
	always_comb begin
		req_ready = 1'b0;
		we        = 1'b0;
		wa        = pos_q;
		wd        = down_q;
		ra0       = '0;
		ra1       = '0;
		emit      = 1'b0;
		emit_res  = res_q;
		unique case (state_q)
			S_IDLE: req_ready = 1'b1;
			S_PUSH_RD: begin
				ra0 = up_idx;
				if (pos_q == '0) begin
					we = 1'b1;
					wd = new_q;
				end
			end
			S_PUSH_CMP: begin
				we = 1'b1;
				wd = (new_q.expire < rd0_q.expire) ? rd0_q : new_q;
			end
			S_DSP_CHK: begin
				// keep the root in view while the result side stalls
				ra0 = chk_go ? AW'(cnt_m1) : '0;
				if (due && chk_go && pend_v_q) begin
					emit                   = 1'b1;
					emit_res.kind          = KIND_EXPIRED;
					emit_res.timer_handle  = pend_q.handle;
					emit_res.timer_session = pend_q.session;
					emit_res.timeout_ms    = '0;
					emit_res.last          = 1'b0;
				end
			end
			S_SIFT_RD: begin
				ra0 = AW'(child_q);
				ra1 = AW'(child_p1);
				if (!child_in) begin
					we = 1'b1;
				end
			end
			S_SIFT_CMP: begin
				we = 1'b1;
				wd = sink ? ce : down_q;
			end
			S_DSP_END: begin
				emit                   = emit_ok;
				emit_res.kind          = pend_v_q ? KIND_EXPIRED : KIND_NONE_DUE;
				emit_res.timer_handle  = pend_v_q ? pend_q.handle : '0;
				emit_res.timer_session = pend_v_q ? pend_q.session : '0;
				emit_res.timeout_ms    = '0;
				emit_res.last          = 1'b1;
			end
			S_EMIT: emit = emit_ok;
			default: begin
			end
		endcase
	end

	// heap memory, one write and two registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd0_q <= mem[ra0];
		rd1_q <= mem[ra1];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				pos_q  <= AW'(cnt_q);
				new_q  <= '{expire: exp_sat, handle: req.cmd.handle, session: req.cmd.session};
				res_q  <= '{kind: KIND_FULL, timer_handle: '0, timer_session: '0,
					timeout_ms: '0, last: 1'b1};
			end
			S_PUSH_RD: begin
				if (pos_q == '0) begin
					res_q.kind <= KIND_REGISTERED;
				end
			end
			S_PUSH_CMP: begin
				if (new_q.expire < rd0_q.expire) begin
					pos_q <= up_idx;
				end else begin
					res_q.kind <= KIND_REGISTERED;
				end
			end
			S_DSP_CHK: begin
				if (due && chk_go) begin
					pend_q <= rd0_q;
				end
			end
			S_POP_LD: begin
				down_q  <= rd0_q;
				pos_q   <= '0;
				child_q <= XW'(1);
			end
			S_SIFT_CMP: begin
				pos_q   <= AW'(c_idx);
				child_q <= XW'({c_idx, 1'b1});
			end
			S_QRY_RD: begin
				res_q.kind       <= KIND_TIMEOUT;
				res_q.timeout_ms <= TIMEOUT_EMPTY;
			end
			S_QRY_RES: res_q.timeout_ms <= {1'b0, tmo};
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			lat_q    <= '0;
			stale_q  <= 1'b1;
			pend_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && req.valid) begin
				if (req.cmd.op == OP_QUERY) begin
					lat_q   <= req.cmd.now_ms;
					stale_q <= 1'b1;
				end else if (req.cmd.op == OP_DISPATCH && stale_q) begin
					lat_q   <= req.cmd.now_ms;
					stale_q <= 1'b0;
				end
			end
			if (we && (state_q == S_PUSH_RD || (state_q == S_PUSH_CMP &&
				!(new_q.expire < rd0_q.expire)))) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == S_DSP_CHK && due && chk_go) begin
				cnt_q    <= cnt_m1;
				pend_v_q <= 1'b1;
			end
			if (state_q == S_DSP_END && emit_ok) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (emit) begin
			ov_q <= 1'b1;
		end else if (evt_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			od_q <= emit_res;
		end
	end

	assign evt_valid = ov_q;
	assign evt_data  = od_q;

	// heap never holds more entries than its depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(HEAP_DEPTH))
		else $error("heap count above depth");

	// a pop removes exactly one entry
	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DSP_CHK && due && chk_go) |=> cnt_q == $past(cnt_m1))
		else $error("pop did not decrement count");

	// no held expired timer outside a dispatch
	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !pend_v_q)
		else $error("pending timer left after dispatch");

	// a result is only produced into a free or draining output register
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!ov_q || evt_ready))
		else $error("result overwrites a waiting result");

endmodule

`default_nettype wire

// ----- rtl/core/timer_min_heap_queue.sv -----
// ----------------------------------------------------------------------------
// timer_min_heap_queue: pending timers kept in a binary min-heap
//
//  channel | dir | handshake          | payload
//  cmd     | in  | cmd.valid/ready    | func, now_ms, handle, session, interval
//  evt     | out | evt.valid/ready    | kind, timer_handle, timer_session,
//          |     |                    | timeout_ms, last
//
// One command runs at a time in the heap engine; a two-item command queue
// sits in front of it. Register climbs the heap level by level, query reads
// the root, dispatch pops each expired timer and sinks its replacement level
// by level; the single heap memory with one write port paces these steps.
// Reset clears the count and latched time and sets the stale flag; the heap
// memory is not cleared. A stalled result channel holds the engine, the queue
// keeps taking commands until full.
// ----------------------------------------------------------------------------
`default_nettype none

module timer_min_heap_queue #(
	parameter int HEAP_DEPTH = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	tmhq_cmd_if.sink  cmd,
	tmhq_evt_if.source evt
);
	import tmhq_pkg::*;

	cmd_req_t req;
	logic     req_ready;
	res_t     evt_data;
	logic     evt_valid;

	// command intake
	tmhq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.req_ready (req_ready)
	);

	// heap engine
	tmhq_engine #(
		.HEAP_DEPTH (HEAP_DEPTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.evt_data  (evt_data),
		.req_ready (req_ready),
		.evt_valid (evt_valid),
		.evt_ready (evt.ready)
	);

	// result channel
	assign evt.valid         = evt_valid;
	assign evt.kind          = evt_data.kind;
	assign evt.timer_handle  = evt_data.timer_handle;
	assign evt.timer_session = evt_data.timer_session;
	assign evt.timeout_ms    = evt_data.timeout_ms;
	assign evt.last          = evt_data.last;

endmodule

`default_nettype wire
